// ----- rtl/stp_pkg.sv -----
// Shared types and constants for the secant target predictor.
package stp_pkg;

	typedef struct packed {
		logic        action;
		logic [31:0] x_value;
		logic [31:0] y_value;
	} item_t;

	typedef struct packed {
		logic [31:0] predicted_y;
		logic [31:0] used_x;
		logic [2:0]  status;
		logic        was_clamped;
	} result_t;

	localparam logic [2:0] STS_INTERP    = 3'd0;
	localparam logic [2:0] STS_STEP      = 3'd1;
	localparam logic [2:0] STS_AT_TARGET = 3'd2;
	localparam logic [2:0] STS_NO_POINTS = 3'd3;
	localparam logic [2:0] STS_ABOVE     = 3'd4;
	localparam logic [2:0] STS_BELOW     = 3'd5;

	localparam logic [2:0] CFG_BASE_MULT  = 3'd0;
	localparam logic [2:0] CFG_EXTRAP     = 3'd1;
	localparam logic [2:0] CFG_SLOPE_POS  = 3'd2;
	localparam logic [2:0] CFG_Y_LOWER    = 3'd3;
	localparam logic [2:0] CFG_Y_UPPER    = 3'd4;

	localparam logic        ACT_ADD     = 1'b0;
	localparam logic        ACT_PREDICT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXT,
		S_BOUNDS,
		S_CLAMP,
		S_PROD_GO,
		S_PROD,
		S_QUOT_GO,
		S_QUOT,
		S_FULL,
		S_STEP_MUL,
		S_STEP_DIV,
		S_DONE
	} state_t;

	function automatic logic [31:0] sat48(input logic signed [47:0] v);
		logic [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/stp_mul.sv -----
// Bit-serial unsigned 32x32 shift-add multiplier.
module stp_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {32'd0, a};
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[62:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[31:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- rtl/stp_div.sv -----
// Radix-2 restoring divider, 65-bit dividend by 32-bit divisor.
module stp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [64:0] quot
);

	logic [64:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;

	assign trial = {1'b0, rem_q, num_q[64]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				num_q <= {num_q[63:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], num_q[64]};
				num_q <= {num_q[63:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- rtl/secant_target_predictor_unit.sv -----
// Top level: two-point secant predictor with clamped extrapolation.
// An add transaction is taken in the idle state and updates the two held points.
// A predict transaction with no points goes straight to the done state, as does
// one at the newer x when no secant can be formed; otherwise a step up runs the
// bit-serial multiplier once and a step down runs the divider once.
// Interpolation runs the multiplier twice and the divider once. One transaction
// is in work at a time; a finished result waits in the output register while the next transaction is taken.
module secant_target_predictor_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  stp_pkg::item_t         item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output stp_pkg::result_t       result,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	stp_pkg::state_t state_q, state_d;

	logic [15:0] base_q, extrap_q;
	logic        slope_q;
	logic signed [31:0] ylo_q, yhi_q;
	logic signed [31:0] ox_q, oy_q, nx_q, ny_q;
	logic [1:0]  held_q;

	logic signed [31:0] tgt_q, used_q;
	logic        clamped_q;
	logic signed [37:0] lo_q, hi_q;
	logic [31:0] ry_q;
	logic [2:0]  rstat_q;
	logic        out_valid_q;
	stp_pkg::result_t out_q;

	logic        mul_start, div_start, mul_done, div_done;
	logic [31:0] mul_a, mul_b, div_den;
	logic [64:0] div_num, quot;
	logic [63:0] prod;

	logic        accept, out_free, two_ok, up;
	logic signed [32:0] dx, dy, dt;
	logic [31:0] span, dymag, dtmag, nymag;
	logic [15:0] base_eff;
	logic signed [31:0] minx, maxx;
	logic [35:0] ext;
	logic signed [37:0] tgt38;
	logic [34:0] qc;
	logic        neg;
	logic signed [36:0] full;
	logic [35:0] qup;
	logic signed [47:0] sval_up, sval_dn;

	assign accept   = item_valid && (state_q == stp_pkg::S_IDLE);
	assign out_free = !out_valid_q || !result_stall;

	assign dx    = {nx_q[31], nx_q} - {ox_q[31], ox_q};
	assign dy    = {ny_q[31], ny_q} - {oy_q[31], oy_q};
	assign dt    = {used_q[31], used_q} - {ox_q[31], ox_q};
	assign span  = dx[32] ? 32'(-dx) : dx[31:0];
	assign dymag = dy[32] ? 32'(-dy) : dy[31:0];
	assign dtmag = dt[32] ? 32'(-dt) : dt[31:0];
	assign nymag = ny_q[31] ? 32'(-ny_q) : ny_q;
	assign base_eff = (base_q == 16'd0) ? 16'd1 : base_q;
	assign two_ok = (held_q == 2'd2) && (ox_q != nx_q) && (oy_q != ny_q);
	assign up = (($signed(item.x_value) > nx_q) == slope_q);
	assign minx = (ox_q < nx_q) ? ox_q : nx_q;
	assign maxx = (ox_q < nx_q) ? nx_q : ox_q;
	assign ext = prod[47:12];
	assign tgt38 = 38'(tgt_q);

	assign qc   = (quot > 65'h4_0000_0000) ? 35'h4_0000_0000 : quot[34:0];
	assign neg  = ((dy[32] != dt[32]) != dx[32]);
	assign full = neg ? (37'(oy_q) - $signed({2'b00, qc}))
	                  : (37'(oy_q) + $signed({2'b00, qc}));

	assign qup     = 36'((prod + 64'd2048) >> 12);
	assign sval_up = ny_q[31] ? -$signed({12'd0, qup}) : $signed({12'd0, qup});
	assign sval_dn = ny_q[31] ? -$signed({3'd0, quot[44:0]})
	                          : $signed({3'd0, quot[44:0]});

	stp_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	stp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stp_pkg::S_IDLE: begin
				if (accept && item.action != stp_pkg::ACT_ADD) begin
					if (held_q == 2'd0)
						state_d = stp_pkg::S_DONE;
					else if (!two_ok) begin
						if ($signed(item.x_value) == nx_q)
							state_d = stp_pkg::S_DONE;
						else if (up)
							state_d = stp_pkg::S_STEP_MUL;
						else
							state_d = stp_pkg::S_STEP_DIV;
					end else
						state_d = stp_pkg::S_EXT;
				end
			end
			stp_pkg::S_EXT:      if (mul_done) state_d = stp_pkg::S_BOUNDS;
			stp_pkg::S_BOUNDS:   state_d = stp_pkg::S_CLAMP;
			stp_pkg::S_CLAMP:    state_d = stp_pkg::S_PROD_GO;
			stp_pkg::S_PROD_GO:  state_d = stp_pkg::S_PROD;
			stp_pkg::S_PROD:     if (mul_done) state_d = stp_pkg::S_QUOT_GO;
			stp_pkg::S_QUOT_GO:  state_d = stp_pkg::S_QUOT;
			stp_pkg::S_QUOT:     if (div_done) state_d = stp_pkg::S_FULL;
			stp_pkg::S_FULL:     state_d = stp_pkg::S_DONE;
			stp_pkg::S_STEP_MUL: if (mul_done) state_d = stp_pkg::S_DONE;
			stp_pkg::S_STEP_DIV: if (div_done) state_d = stp_pkg::S_DONE;
			stp_pkg::S_DONE:     if (out_free) state_d = stp_pkg::S_IDLE;
			default:             state_d = stp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = span;
		mul_b     = {16'd0, extrap_q};
		div_num   = {1'b0, prod} + {34'd0, span[31:1]};
		div_den   = span;
		unique case (state_q)
			stp_pkg::S_IDLE: begin
				if (state_d == stp_pkg::S_EXT)
					mul_start = 1'b1;
				if (state_d == stp_pkg::S_STEP_MUL) begin
					mul_start = 1'b1;
					mul_a     = nymag;
					mul_b     = {16'd0, base_eff};
				end
				if (state_d == stp_pkg::S_STEP_DIV) begin
					div_start = 1'b1;
					div_num   = {21'd0, nymag, 12'd0} + {50'd0, base_eff[15:1]};
					div_den   = {16'd0, base_eff};
				end
			end
			stp_pkg::S_PROD_GO: begin
				mul_start = 1'b1;
				mul_a     = dymag;
				mul_b     = dtmag;
			end
			stp_pkg::S_QUOT_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			base_q      <= 16'd4506;
			extrap_q    <= 16'd4096;
			slope_q     <= 1'b1;
			ylo_q       <= 32'sh8000_0000;
			yhi_q       <= 32'sh7FFF_FFFF;
			held_q      <= 2'd0;
			ox_q        <= '0;
			oy_q        <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == stp_pkg::S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					stp_pkg::CFG_BASE_MULT: base_q   <= cfg_data[15:0];
					stp_pkg::CFG_EXTRAP:    extrap_q <= cfg_data[15:0];
					stp_pkg::CFG_SLOPE_POS: slope_q  <= cfg_data[0];
					stp_pkg::CFG_Y_LOWER:   ylo_q    <= cfg_data;
					stp_pkg::CFG_Y_UPPER:   yhi_q    <= cfg_data;
					default: ;
				endcase
			end
			if (accept && item.action == stp_pkg::ACT_ADD) begin
				ox_q <= nx_q;
				oy_q <= ny_q;
				nx_q <= item.x_value;
				ny_q <= item.y_value;
				if (held_q != 2'd2)
					held_q <= held_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q     <= item.x_value;
			used_q    <= item.x_value;
			clamped_q <= 1'b0;
			if (held_q == 2'd0) begin
				ry_q    <= '0;
				rstat_q <= stp_pkg::STS_NO_POINTS;
			end else begin
				ry_q    <= ny_q;
				rstat_q <= stp_pkg::STS_AT_TARGET;
			end
		end
		if (state_q == stp_pkg::S_BOUNDS) begin
			lo_q <= 38'(minx) - $signed({2'b00, ext});
			hi_q <= 38'(maxx) + $signed({2'b00, ext});
		end
		if (state_q == stp_pkg::S_CLAMP) begin
			if (tgt38 > hi_q) begin
				used_q    <= hi_q[31:0];
				clamped_q <= 1'b1;
			end else if (tgt38 < lo_q) begin
				used_q    <= lo_q[31:0];
				clamped_q <= 1'b1;
			end
		end
		if (state_q == stp_pkg::S_FULL) begin
			ry_q <= stp_pkg::sat48(48'(full));
			if (full > 37'(yhi_q))
				rstat_q <= stp_pkg::STS_ABOVE;
			else if (full < 37'(ylo_q))
				rstat_q <= stp_pkg::STS_BELOW;
			else
				rstat_q <= stp_pkg::STS_INTERP;
		end
		if (state_q == stp_pkg::S_STEP_MUL && mul_done) begin
			ry_q    <= stp_pkg::sat48(sval_up);
			rstat_q <= stp_pkg::STS_STEP;
		end
		if (state_q == stp_pkg::S_STEP_DIV && div_done) begin
			ry_q    <= stp_pkg::sat48(sval_dn);
			rstat_q <= stp_pkg::STS_STEP;
		end
		if (state_q == stp_pkg::S_DONE && out_free) begin
			out_q.predicted_y <= ry_q;
			out_q.used_x      <= used_q;
			out_q.status      <= rstat_q;
			out_q.was_clamped <= clamped_q;
		end
	end

	assign item_stall   = (state_q != stp_pkg::S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
